FILE: rtl/pob_pkg.sv
// ----------------------------------------------------------------------------
// pob_pkg
// Shared constants for the pixel over blend unit.
// ----------------------------------------------------------------------------
package pob_pkg;

   // colour lanes, one per channel
   localparam int unsigned LANE_COUNT = 3;

   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } channel_type;

   // compare and subtract steps after the full scale quotient estimate
   localparam int unsigned FSDIV_CORR = 4;

endpackage

FILE: rtl/pob_fsdiv.sv
// ----------------------------------------------------------------------------
// pob_fsdiv
// Truncating division by full scale (2^n - 1) without a divider.
// ----------------------------------------------------------------------------
module pob_fsdiv #(
   parameter int unsigned CHANNEL_BITS = 8
) (
   input  logic [3*CHANNEL_BITS-1:0] x,
   output logic [2*CHANNEL_BITS-1:0] q
);
   import pob_pkg::*;

   localparam int unsigned W = 3 * CHANNEL_BITS + 2;
   localparam logic [W-1:0] FS_W = W'((64'd1 << CHANNEL_BITS) - 64'd1);

   logic [W-1:0] xe;
   logic [W-1:0] q0;
   logic [W-1:0] r;
   logic [2:0]   corr;

   always_comb begin
      xe   = W'(x);
      q0   = (xe >> CHANNEL_BITS) + (xe >> (2 * CHANNEL_BITS)) + (xe >> (3 * CHANNEL_BITS));
      r    = xe + q0 - (q0 << CHANNEL_BITS);
      corr = 3'd0;
      for (int k = 1; k <= FSDIV_CORR; k++) begin
         if (r >= W'(k) * FS_W) begin
            corr = corr + 3'd1;
         end
      end
      q = (2 * CHANNEL_BITS)'(q0 + W'(corr));
   end

endmodule

FILE: rtl/pob_div.sv
// ----------------------------------------------------------------------------
// pob_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module pob_div #(
   parameter int unsigned CHANNEL_BITS = 8
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [2*CHANNEL_BITS:0]   num,
   input  logic [CHANNEL_BITS-1:0]   dvs,
   output logic [CHANNEL_BITS-1:0]   quo
);
   import pob_pkg::*;

   localparam int unsigned N     = CHANNEL_BITS;
   localparam int unsigned NUM_W = 2 * CHANNEL_BITS + 1;
   localparam int unsigned CMP_W = NUM_W + CHANNEL_BITS;
   localparam logic [N-1:0] FS   = '1;

   logic [NUM_W-1:0] rem_in [N];
   logic [NUM_W-1:0] rem_ff [N];
   logic [N-1:0]     q_in   [N];
   logic [N-1:0]     q_ff   [N];
   logic [N-1:0]     dvs_ff [N];
   logic             sat_in [N];
   logic             sat_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [NUM_W-1:0] rem_src;
      logic [N-1:0]     q_src;
      logic [N-1:0]     dvs_src;
      logic             sat_src;
      logic [CMP_W-1:0] trial;

      if (k == 0) begin : g_first
         assign rem_src = num;
         assign q_src   = '0;
         assign dvs_src = dvs;
         assign sat_src = CMP_W'(num) >= (CMP_W'(dvs) << N);
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign q_src   = q_ff[k-1];
         assign dvs_src = dvs_ff[k-1];
         assign sat_src = sat_ff[k-1];
      end

      always_comb begin
         trial     = CMP_W'(dvs_src) << (N - 1 - k);
         sat_in[k] = sat_src;
         if (CMP_W'(rem_src) >= trial) begin
            rem_in[k]        = NUM_W'(CMP_W'(rem_src) - trial);
            q_in[k]          = q_src;
            q_in[k][N-1-k]   = 1'b1;
         end else begin
            rem_in[k] = rem_src;
            q_in[k]   = q_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            dvs_ff[k] <= dvs_src;
            sat_ff[k] <= sat_in[k];
         end
      end
   end

   assign quo = sat_ff[N-1] ? FS : q_ff[N-1];

endmodule

FILE: rtl/pob_lane.sv
// ----------------------------------------------------------------------------
// pob_lane
// One colour channel: weighted sum of source and destination, then divide by
// the output coverage.
// ----------------------------------------------------------------------------
module pob_lane #(
   parameter int unsigned CHANNEL_BITS = 8
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [CHANNEL_BITS-1:0]     src,
   input  logic [CHANNEL_BITS-1:0]     dst,
   input  logic [CHANNEL_BITS-1:0]     inv_s,
   input  logic [2*CHANNEL_BITS-1:0]   st_inv_d,
   input  logic [CHANNEL_BITS-1:0]     cov,
   output logic [CHANNEL_BITS-1:0]     quo
);
   import pob_pkg::*;

   localparam int unsigned N = CHANNEL_BITS;

   logic [2*N-1:0] p1_ff;
   logic [N-1:0]   dst_ff;
   logic [3*N-1:0] b_ff;
   logic [2*N-1:0] p1b_ff;
   logic [2*N-1:0] b_div;
   logic [2*N:0]   num_ff;

   pob_fsdiv #(.CHANNEL_BITS(N)) u_fsdiv (
      .x (b_ff),
      .q (b_div)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff  <= inv_s * src;
         dst_ff <= dst;
         b_ff   <= (3*N)'(st_inv_d) * (3*N)'(dst_ff);
         p1b_ff <= p1_ff;
         num_ff <= (2*N+1)'(p1b_ff) + (2*N+1)'(b_div);
      end
   end

   pob_div #(.CHANNEL_BITS(N)) u_div (
      .clock (clock),
      .en    (en),
      .num   (num_ff),
      .dvs   (cov),
      .quo   (quo)
   );

endmodule

FILE: rtl/pixel_over_blend_unit.sv
// ----------------------------------------------------------------------------
// pixel_over_blend_unit
// Porter-Duff over of a source pixel on a destination pixel, non-premultiplied,
// opacity held as transparency. Three channel lanes and a merging output stage.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle; the divider is pipelined one bit per stage
// the whole pipeline holds while a result beat waits on rsp_tready
// reset clears the valid bits only; no other state
// ----------------------------------------------------------------------------
module pixel_over_blend_unit #(
   parameter int unsigned CHANNEL_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // src_red, src_green, src_blue, src_transparency,
   // dst_red, dst_green, dst_blue, dst_transparency
   input  logic [8*CHANNEL_BITS-1:0]               req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // out_red, out_green, out_blue, out_transparency, zero fill
   output logic [((4*CHANNEL_BITS+7)/8)*8-1:0]     rsp_tdata
);
   import pob_pkg::*;

   localparam int unsigned N      = CHANNEL_BITS;
   localparam int unsigned OUT_W  = ((4 * CHANNEL_BITS + 7) / 8) * 8;
   localparam int unsigned BYP_D  = CHANNEL_BITS + 3;
   localparam int unsigned VLD_D  = CHANNEL_BITS + 4;
   localparam logic [N-1:0] FS    = '1;

   typedef struct packed {
      logic         pass;
      logic [N-1:0] red;
      logic [N-1:0] green;
      logic [N-1:0] blue;
      logic [N-1:0] transp;
   } bypass_type;

   logic           en;
   logic [N-1:0]   src_ff [LANE_COUNT];
   logic [N-1:0]   dst_ff [LANE_COUNT];
   logic [N-1:0]   st_ff;
   logic [N-1:0]   dt_ff;
   logic [N-1:0]   inv_s;
   logic [N-1:0]   inv_s2_ff;
   logic [2*N-1:0] a_in;
   logic [2*N-1:0] a_ff;
   logic [2*N-1:0] a_div;
   logic [N-1:0]   cov_ff;
   logic [N-1:0]   cov2_ff;
   logic [N-1:0]   covd_ff [N];
   logic [N-1:0]   quo [LANE_COUNT];
   bypass_type     byp_in;
   bypass_type     byp_ff [BYP_D];
   logic [VLD_D-1:0] vld_ff;
   logic             rsp_tvalid_ff;
   logic [OUT_W-1:0] rsp_tdata_ff;
   logic [OUT_W-1:0] rsp_tdata_in;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // input stage
   always_ff @(posedge clock) begin
      if (en) begin
         src_ff[CH_RED]   <= req_tdata[0*N +: N];
         src_ff[CH_GREEN] <= req_tdata[1*N +: N];
         src_ff[CH_BLUE]  <= req_tdata[2*N +: N];
         st_ff            <= req_tdata[3*N +: N];
         dst_ff[CH_RED]   <= req_tdata[4*N +: N];
         dst_ff[CH_GREEN] <= req_tdata[5*N +: N];
         dst_ff[CH_BLUE]  <= req_tdata[6*N +: N];
         dt_ff            <= req_tdata[7*N +: N];
      end
   end

   // shared coverage path
   assign inv_s = FS - st_ff;
   assign a_in  = st_ff * (FS - dt_ff);

   pob_fsdiv #(.CHANNEL_BITS(N)) u_cov_div (
      .x ((3*N)'(a_ff)),
      .q (a_div)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff      <= a_in;
         inv_s2_ff <= inv_s;
         cov_ff    <= N'((2*N)'(inv_s2_ff) + a_div);
         cov2_ff   <= cov_ff;
         covd_ff[0] <= cov2_ff;
         for (int k = 1; k < N; k++) begin
            covd_ff[k] <= covd_ff[k-1];
         end
      end
   end

   for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
      pob_lane #(.CHANNEL_BITS(N)) u_lane (
         .clock    (clock),
         .en       (en),
         .src      (src_ff[l]),
         .dst      (dst_ff[l]),
         .inv_s    (inv_s),
         .st_inv_d (a_ff),
         .cov      (cov2_ff),
         .quo      (quo[l])
      );
   end

   // pass-through cases
   always_comb begin
      byp_in.pass = (st_ff == FS) || (st_ff == '0);
      if (st_ff == FS) begin
         byp_in.red    = dst_ff[CH_RED];
         byp_in.green  = dst_ff[CH_GREEN];
         byp_in.blue   = dst_ff[CH_BLUE];
         byp_in.transp = dt_ff;
      end else begin
         byp_in.red    = src_ff[CH_RED];
         byp_in.green  = src_ff[CH_GREEN];
         byp_in.blue   = src_ff[CH_BLUE];
         byp_in.transp = st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         byp_ff[0] <= byp_in;
         for (int k = 1; k < BYP_D; k++) begin
            byp_ff[k] <= byp_ff[k-1];
         end
      end
   end

   // merge
   always_comb begin
      rsp_tdata_in = '0;
      if (byp_ff[BYP_D-1].pass) begin
         rsp_tdata_in[0*N +: N] = byp_ff[BYP_D-1].red;
         rsp_tdata_in[1*N +: N] = byp_ff[BYP_D-1].green;
         rsp_tdata_in[2*N +: N] = byp_ff[BYP_D-1].blue;
         rsp_tdata_in[3*N +: N] = byp_ff[BYP_D-1].transp;
      end else begin
         rsp_tdata_in[0*N +: N] = quo[CH_RED];
         rsp_tdata_in[1*N +: N] = quo[CH_GREEN];
         rsp_tdata_in[2*N +: N] = quo[CH_BLUE];
         rsp_tdata_in[3*N +: N] = FS - covd_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= {vld_ff[VLD_D-2:0], req_tvalid};
         rsp_tvalid_ff <= vld_ff[VLD_D-1];
      end
   end

endmodule
